>>> rtl/mbrc_pkg.sv
// Shared types, codes and the CRC-16 byte step for the response checker.
package mbrc_pkg;

	localparam int MAX_WORDS_DEF = 32;

	localparam logic [7:0] FN_READ  = 8'h03;
	localparam logic [7:0] FN_WRITE = 8'h06;
	localparam logic [15:0] WRITE_LEN = 16'd8;
	localparam logic [15:0] READ_HDR_LEN = 16'd5;
	localparam logic [15:0] WORD_BASE_POS = 16'd3;
	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		CFG_MODE      = 3'd0,
		CFG_SLAVE     = 3'd1,
		CFG_COUNT     = 3'd2,
		CFG_REG_ADDR  = 3'd3,
		CFG_REG_VAL   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_CRC   = 3'd2,
		ST_ADDR  = 3'd3,
		ST_FUNC  = 3'd4,
		ST_COUNT = 3'd5,
		ST_ECHO  = 3'd6,
		ST_SETUP = 3'd7
	} status_t;

	// Bit positions in the mismatch flags.
	localparam int FL_ADDR  = 0;
	localparam int FL_FUNC  = 1;
	localparam int FL_COUNT = 2;
	localparam int FL_ECHO  = 3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIN,
		S_RD,
		S_LOAD,
		S_STAT
	} fsm_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/mbrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mbrc_ram #(
	parameter int W = 16,
	parameter int D = 32,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/modbus_response_checker_unit.sv
// Top level: checks a received response frame byte by byte and reports words and status.
//
// Usage:
//   Frame bytes enter on the s_axis channel, one beat per byte, tlast on the
//   final byte. The frame status is decided in the cycle after the final
//   byte, in S_FIN. The input stays closed from the final byte until the
//   status beat is loaded in S_STAT, passing S_RD and S_LOAD first for a
//   passing read frame, and for as long as m_axis stalls.
//   Results leave on the m_axis channel through an output register. A passing
//   read frame gives its n register words (tuser 0), then a status beat
//   (tuser 1, tlast 1). Any other frame gives only the status beat.
//   Words are read back from the word RAM: the first read in S_RD, then one
//   word per cycle while the receiver takes them, the next word fetched
//   while the current one goes out.
//   Write the configuration port only while no frame is in progress.
//   Reset clears the frame state and the registers to their defaults; the
//   word RAM is not cleared. A stall on m_axis holds the output beat and the
//   drain; the input waits until the drain has finished.
module modbus_response_checker_unit
	import mbrc_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// Frame bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tlast,   // last_byte
	// Results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [5:0] word_index, [21:6] word_value, [24:22] status
	output logic        m_axis_tuser,   // item_kind
	output logic        m_axis_tlast    // run_end
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam logic [6:0]  MAX_WORDS_7  = 7'(MAX_WORDS);
	localparam logic [14:0] MAX_WORDS_15 = 15'(MAX_WORDS);

	// Configuration registers
	logic        mode_q;
	logic [7:0]  exp_slave_q;
	logic [5:0]  exp_count_q;
	logic [15:0] exp_addr_q;
	logic [15:0] exp_val_q;

	// Frame state
	logic [15:0] pos_q;
	logic [15:0] crc_q;
	logic [3:0]  flags_q;
	logic [7:0]  pend_q;

	fsm_t        state_q, state_d;
	logic [5:0]  idx_q;
	status_t     stat_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [5:0]  out_idx_q;
	logic [15:0] out_val_q;
	status_t     out_st_q;

	logic          in_acc;
	logic          can_load;
	logic          last_word;
	logic [3:0]    flags_d;
	logic [15:0]   off;
	logic [14:0]   wsel;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	logic          load_word;
	logic          load_stat;
	status_t       fin_st;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign can_load      = ~out_valid_q | m_axis_tready;
	assign last_word     = ({1'b0, idx_q} + 7'd1) == {1'b0, exp_count_q};

	assign off    = pos_q - WORD_BASE_POS;
	assign wsel   = off[15:1];
	assign ram_we = in_acc & (pos_q >= WORD_BASE_POS) & off[0] & (wsel < MAX_WORDS_15);

	// Per-byte header compares
	always_comb begin
		flags_d = flags_q;
		if (pos_q == 16'd0 && s_axis_tdata != exp_slave_q) begin
			flags_d[FL_ADDR] = 1'b1;
		end
		if (pos_q == 16'd1 && s_axis_tdata != (mode_q ? FN_WRITE : FN_READ)) begin
			flags_d[FL_FUNC] = 1'b1;
		end
		if (pos_q == 16'd2 && s_axis_tdata != {1'b0, exp_count_q, 1'b0}) begin
			flags_d[FL_COUNT] = 1'b1;
		end
		if ((pos_q == 16'd2 && s_axis_tdata != exp_addr_q[15:8]) ||
		    (pos_q == 16'd3 && s_axis_tdata != exp_addr_q[7:0]) ||
		    (pos_q == 16'd4 && s_axis_tdata != exp_val_q[15:8]) ||
		    (pos_q == 16'd5 && s_axis_tdata != exp_val_q[7:0])) begin
			flags_d[FL_ECHO] = 1'b1;
		end
	end

	// Frame verdict; pos_q already holds the frame length here
	always_comb begin
		if (!mode_q) begin
			if (exp_count_q == 6'd0 || {1'b0, exp_count_q} > MAX_WORDS_7) begin
				fin_st = ST_SETUP;
			end else if (pos_q < READ_HDR_LEN + {9'd0, exp_count_q, 1'b0}) begin
				fin_st = ST_SHORT;
			end else if (crc_q != 16'd0) begin
				fin_st = ST_CRC;
			end else if (flags_q[FL_ADDR]) begin
				fin_st = ST_ADDR;
			end else if (flags_q[FL_FUNC]) begin
				fin_st = ST_FUNC;
			end else if (flags_q[FL_COUNT]) begin
				fin_st = ST_COUNT;
			end else begin
				fin_st = ST_OK;
			end
		end else begin
			if (pos_q < WRITE_LEN) begin
				fin_st = ST_SHORT;
			end else if (crc_q != 16'd0) begin
				fin_st = ST_CRC;
			end else if (flags_q[FL_ADDR]) begin
				fin_st = ST_ADDR;
			end else if (flags_q[FL_FUNC]) begin
				fin_st = ST_FUNC;
			end else if (flags_q[FL_ECHO]) begin
				fin_st = ST_ECHO;
			end else begin
				fin_st = ST_OK;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		load_word = 1'b0;
		load_stat = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && s_axis_tlast) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = (!mode_q && fin_st == ST_OK) ? S_RD : S_STAT;
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (can_load) begin
					load_word = 1'b1;
					if (last_word) begin
						state_d = S_STAT;
					end else begin
						// fetch the next word while this one goes out
						ram_re    = 1'b1;
						ram_raddr = idx_q[AW-1:0] + AW'(1);
					end
				end
			end
			S_STAT: begin
				if (can_load) begin
					load_stat = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			exp_slave_q <= 8'd1;
			exp_count_q <= 6'd1;
			exp_addr_q  <= 16'd0;
			exp_val_q   <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q      <= cfg_wdata[0];
				CFG_SLAVE:    exp_slave_q <= cfg_wdata[7:0];
				CFG_COUNT:    exp_count_q <= cfg_wdata[5:0];
				CFG_REG_ADDR: exp_addr_q  <= cfg_wdata;
				CFG_REG_VAL:  exp_val_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 16'd0;
			crc_q   <= CRC_INIT;
			flags_q <= 4'd0;
			pend_q  <= 8'd0;
		end else if (state_q == S_FIN) begin
			// drop the frame state once the verdict is taken
			pos_q   <= 16'd0;
			crc_q   <= CRC_INIT;
			flags_q <= 4'd0;
			pend_q  <= 8'd0;
		end else if (in_acc) begin
			crc_q   <= crc16_byte(crc_q, s_axis_tdata);
			flags_q <= flags_d;
			if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 16'd1;
			end
			if (pos_q >= WORD_BASE_POS && !off[0]) begin
				pend_q <= s_axis_tdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 6'd0;
			stat_q <= ST_OK;
		end else if (state_q == S_FIN) begin
			idx_q  <= 6'd0;
			stat_q <= fin_st;
		end else if (load_word) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_word || load_stat) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			out_kind_q <= 1'b0;
			out_idx_q  <= idx_q;
			out_val_q  <= ram_rdata;
			out_st_q   <= ST_OK;
		end else if (load_stat) begin
			out_kind_q <= 1'b1;
			out_idx_q  <= 6'd0;
			out_val_q  <= 16'd0;
			out_st_q   <= stat_q;
		end
	end

	mbrc_ram #(
		.W (16),
		.D (MAX_WORDS)
	) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wsel[AW-1:0]),
		.wdata ({pend_q, s_axis_tdata}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_st_q, out_val_q, out_idx_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_kind_q;

endmodule
